// ----- rtl/ubdc_pkg.sv -----
// Shared constants, types and the divider-code table for the baud divisor calculator.
package ubdc_pkg;

    localparam int unsigned INCREMENT_MAX = 65535;
    localparam int unsigned DW            = 64;    // divider operand width
    localparam int unsigned CW            = 7;     // divider step counter width

    typedef logic [DW-1:0] t_word;

    // Divider request from the sequencer
    typedef struct packed {
        logic  start;
        t_word dividend;
        t_word divisor;
    } t_div_req;

    // Divider response back to the sequencer
    typedef struct packed {
        logic  done;
        t_word quot;
        t_word rem_v;
    } t_div_rsp;

    // Dividers 1..7 map to codes 5,4,3,2,1,0,6; anything else reads as 5
    function automatic logic [2:0] div_code(input logic [2:0] d);
        logic [2:0] c;
        begin
            case (d)
                3'd1:    c = 3'd5;
                3'd2:    c = 3'd4;
                3'd3:    c = 3'd3;
                3'd4:    c = 3'd2;
                3'd5:    c = 3'd1;
                3'd6:    c = 3'd0;
                3'd7:    c = 3'd6;
                default: c = 3'd5;
            endcase
            return c;
        end
    endfunction

endpackage

// ----- rtl/ubdc_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module ubdc_div import ubdc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    t_word         r_q, n_q;
    t_word         r_r, n_r;
    t_word         r_d, n_d;
    logic [DW:0]   w_sh;
    logic [DW:0]   w_sub;

    assign w_sh  = {r_r, r_q[DW-1]};
    assign w_sub = w_sh - {1'b0, r_d};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        n_d    = r_d;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_req.dividend;
            n_r    = '0;
            n_d    = i_req.divisor;
        end else if (r_busy) begin
            if (!w_sub[DW]) begin
                n_r = w_sub[DW-1:0];
                n_q = {r_q[DW-2:0], 1'b1};
            end else begin
                n_r = w_sh[DW-1:0];
                n_q = {r_q[DW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(DW-1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        r_d <= n_d;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.quot  = r_q;
    assign o_rsp.rem_v = r_r;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without busy");
    a_no_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && !i_req.start) |=> !r_busy)
        else $error("divider started on its own");

endmodule

// ----- rtl/ubdc_seq.sv -----
// Sequencer: GCD loops, scaling and error test over the shared divider.
module ubdc_seq import ubdc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_clk_hz,
    input  logic        i_go,
    input  logic [23:0] i_baud,
    output logic        o_busy,
    output logic        o_fin,
    output logic        o_ok,
    output logic [2:0]  o_code,
    output logic [15:0] o_inc,
    output logic [15:0] o_mod,
    output t_div_req    o_req,
    input  t_div_rsp    i_rsp
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_G1    = 5'd1;   // euclid step 1
    localparam logic [4:0] S_N1    = 5'd2;   // num = clk / g
    localparam logic [4:0] S_D1    = 5'd3;   // den = 16b / g
    localparam logic [4:0] S_M     = 5'd4;   // m = (num-1)/(7*lim) + 1
    localparam logic [4:0] S_NN    = 5'd5;   // n = (den-1)/lim + 1
    localparam logic [4:0] S_SN    = 5'd6;   // num /= f
    localparam logic [4:0] S_SD    = 5'd7;   // den /= f
    localparam logic [4:0] S_DV    = 5'd8;   // divider = (num-1)/lim + 1
    localparam logic [4:0] S_G2    = 5'd9;
    localparam logic [4:0] S_N2    = 5'd10;  // tnum
    localparam logic [4:0] S_D2    = 5'd11;  // tden
    localparam logic [4:0] S_MUL   = 5'd12;  // tnum*den
    localparam logic [4:0] S_ACH   = 5'd13;  // achieved
    localparam logic [4:0] S_MODV  = 5'd14;  // num / divider
    localparam logic [4:0] S_THR   = 5'd15;  // baud / 100
    localparam logic [4:0] S_DONE  = 5'd16;

    localparam t_word LIM  = t_word'(INCREMENT_MAX);
    localparam t_word LIM7 = t_word'(INCREMENT_MAX * 7);

    logic [4:0]  r_st, n_st;
    logic        r_wait, n_wait;
    t_word       r_a, n_a, r_b, n_b, r_g, n_g;
    t_word       r_num, n_num, r_den, n_den, r_x, n_x, r_y, n_y;
    logic [2:0]  r_dv, n_dv;
    logic        r_ok, n_ok;
    logic [15:0] r_inc, n_inc, r_mod, n_mod;
    logic        r_fin, n_fin;
    logic [31:0] r_mul_a, n_mul_a;   // multiply operand, low half of tnum
    t_word       w_b16, w_diff, w_ach;
    logic [63:0] w_prod;

    assign w_b16 = {36'd0, i_baud, 4'd0};
    assign w_prod = r_mul_a * r_den[31:0];

    always_comb begin
        n_st = r_st; n_wait = 1'b0; n_a = r_a; n_b = r_b; n_g = r_g;
        n_num = r_num; n_den = r_den; n_x = r_x; n_y = r_y; n_dv = r_dv;
        n_ok = r_ok; n_inc = r_inc; n_mod = r_mod; n_fin = 1'b0; n_mul_a = r_mul_a;
        o_req = '0;
        w_ach = '0; w_diff = '0;
        case (r_st)
            S_IDLE: begin
                if (i_go) begin
                    if (i_baud == '0 || i_clk_hz == '0) begin
                        // divider 6 encodes as 0, so every field reads zero
                        n_ok = 1'b0; n_dv = 3'd6; n_inc = '0; n_mod = '0;
                        n_st = S_DONE;
                    end else begin
                        n_a = {32'd0, i_clk_hz}; n_b = w_b16; n_st = S_G1;
                    end
                end
            end
            S_G1, S_G2: begin
                if (!r_wait) begin
                    if (r_b == '0) begin
                        n_g = r_a;
                        n_wait = 1'b1;
                        o_req.start = 1'b1; o_req.dividend = {32'd0, i_clk_hz};
                        o_req.divisor = r_a;
                        n_st = (r_st == S_G1) ? S_N1 : S_N2;
                    end else begin
                        o_req.start = 1'b1; o_req.dividend = r_a; o_req.divisor = r_b;
                        n_wait = 1'b1;
                    end
                end else if (i_rsp.done) begin
                    n_a = r_b; n_b = i_rsp.rem_v;
                end else n_wait = 1'b1;
            end
            default: begin
                if (r_wait && !i_rsp.done) n_wait = 1'b1;
                else if (r_wait || r_st == S_DONE || r_st == S_MUL) begin
                    case (r_st)
                        S_N1: begin
                            n_num = i_rsp.quot; n_wait = 1'b1;
                            o_req.start = 1'b1; o_req.dividend = w_b16; o_req.divisor = r_g;
                            n_st = S_D1;
                        end
                        S_D1: begin
                            n_den = i_rsp.quot;
                            if (r_num > LIM7 || i_rsp.quot > LIM) begin
                                n_wait = 1'b1; o_req.start = 1'b1;
                                o_req.dividend = r_num - 1'b1; o_req.divisor = LIM7;
                                n_st = S_M;
                            end else begin
                                n_wait = 1'b1; o_req.start = 1'b1;
                                o_req.dividend = r_num - 1'b1; o_req.divisor = LIM;
                                n_st = S_DV;
                            end
                        end
                        S_M: begin
                            n_x = i_rsp.quot + 1'b1; n_wait = 1'b1; o_req.start = 1'b1;
                            o_req.dividend = r_den - 1'b1; o_req.divisor = LIM;
                            n_st = S_NN;
                        end
                        S_NN: begin
                            n_y = i_rsp.quot + 1'b1;
                            if (n_y > r_x) n_x = n_y;
                            n_wait = 1'b1; o_req.start = 1'b1;
                            o_req.dividend = r_num; o_req.divisor = n_x;
                            n_st = S_SN;
                        end
                        S_SN: begin
                            n_num = (i_rsp.quot == '0) ? t_word'(1) : i_rsp.quot;
                            n_wait = 1'b1; o_req.start = 1'b1;
                            o_req.dividend = r_den; o_req.divisor = r_x;
                            n_st = S_SD;
                        end
                        S_SD: begin
                            n_den = (i_rsp.quot == '0) ? t_word'(1) : i_rsp.quot;
                            n_wait = 1'b1; o_req.start = 1'b1;
                            o_req.dividend = r_num - 1'b1; o_req.divisor = LIM;
                            n_st = S_DV;
                        end
                        S_DV: begin
                            n_dv = i_rsp.quot[2:0] + 3'd1;
                            n_a = {32'd0, i_clk_hz}; n_b = {r_num[59:0], 4'd0};
                            n_st = S_G2;
                        end
                        S_N2: begin
                            n_mul_a = i_rsp.quot[31:0]; n_wait = 1'b1; o_req.start = 1'b1;
                            o_req.dividend = {r_num[59:0], 4'd0}; o_req.divisor = r_g;
                            n_st = S_D2;
                        end
                        S_D2: begin
                            n_y = i_rsp.quot; n_st = S_MUL;
                        end
                        S_MUL: begin
                            n_x = w_prod; n_st = S_ACH; n_wait = 1'b1;
                            o_req.start = 1'b1; o_req.dividend = w_prod; o_req.divisor = r_y;
                        end
                        S_ACH: begin
                            w_ach = i_rsp.quot;
                            w_diff = (w_ach >= {40'd0, i_baud}) ? w_ach - {40'd0, i_baud}
                                                               : {40'd0, i_baud} - w_ach;
                            n_x = w_diff; n_wait = 1'b1; o_req.start = 1'b1;
                            o_req.dividend = r_num; o_req.divisor = {61'd0, r_dv};
                            n_st = S_MODV;
                        end
                        S_MODV: begin
                            n_mod = i_rsp.quot[15:0] - 16'd1;
                            n_inc = r_den[15:0] - 16'd1;
                            n_wait = 1'b1; o_req.start = 1'b1;
                            o_req.dividend = {40'd0, i_baud}; o_req.divisor = t_word'(100);
                            n_st = S_THR;
                        end
                        S_THR: begin
                            n_ok = r_x < (i_rsp.quot * 3);
                            n_st = S_DONE;
                        end
                        S_DONE: begin
                            n_fin = 1'b1; n_st = S_IDLE;
                        end
                        default: n_st = S_IDLE;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_wait <= 1'b0; r_fin <= 1'b0;
        end else begin
            r_st <= n_st; r_wait <= n_wait; r_fin <= n_fin;
        end
        r_a <= n_a; r_b <= n_b; r_g <= n_g; r_num <= n_num; r_den <= n_den;
        r_x <= n_x; r_y <= n_y; r_dv <= n_dv; r_ok <= n_ok;
        r_inc <= n_inc; r_mod <= n_mod; r_mul_a <= n_mul_a;
    end

    assign o_busy = (r_st != S_IDLE);
    assign o_fin  = r_fin;
    assign o_ok   = r_ok;
    assign o_code = div_code(r_dv);
    assign o_inc  = r_inc;
    assign o_mod  = r_mod;

    a_go_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_IDLE && i_go) |=> r_st != S_IDLE)
        else $error("go ignored");
    a_fin_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> $past(r_st) == S_DONE)
        else $error("finish out of sequence");
    a_start_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.start |-> (!r_wait || i_rsp.done))
        else $error("divider restarted while waiting");

endmodule

// ----- rtl/uart_baud_divisor_calc.sv -----
// Top level: fractional UART baud divisor calculator.
// Each word runs two Euclid loops of up to about 47 steps each plus eight to twelve other
// divisions on the shared divider (a zero baud rate or zero clock skips them all).
// Throughput: one word at a time; a word is taken only when the sequencer is idle and
// no result is waiting or landing. The 64-bit restoring divider sets how long a word takes.
// Reset (synchronous, i_rst_n low): source clock register back to 80 MHz, sequencer
// idle, no result pending.
module uart_baud_divisor_calc import ubdc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [23:0] i_baud_rate,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_settings_valid,
    output logic [2:0]  o_ref_div_code,
    output logic [15:0] o_bin_increment,
    output logic [15:0] o_bin_modulus
);

    logic [31:0] r_clk_hz;
    logic [23:0] r_baud;
    logic        r_ovld;
    logic        w_go, w_busy, w_fin, w_ok;
    logic [2:0]  w_code;
    logic [15:0] w_inc, w_mod;
    t_div_req    w_req;
    t_div_rsp    w_rsp;

    // take a word only when the sequencer is idle and no result is waiting or landing
    assign o_stall = w_busy || r_ovld || w_fin;
    assign w_go    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= 32'd80000000;
            r_ovld   <= 1'b0;
        end else begin
            if (i_cfg_we) r_clk_hz <= i_cfg_wdata;
            if (w_fin) r_ovld <= 1'b1;
            else if (r_ovld && !i_stall) r_ovld <= 1'b0;
        end
        if (w_go) r_baud <= i_baud_rate;
    end

    ubdc_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clk_hz(r_clk_hz),
        .i_go(w_go), .i_baud(w_go ? i_baud_rate : r_baud),
        .o_busy(w_busy), .o_fin(w_fin), .o_ok(w_ok), .o_code(w_code),
        .o_inc(w_inc), .o_mod(w_mod), .o_req(w_req), .i_rsp(w_rsp)
    );

    ubdc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp)
    );

    // sequencer holds its outputs until the next word starts
    assign o_valid          = r_ovld;
    assign o_settings_valid = w_ok;
    assign o_ref_div_code   = w_code;
    assign o_bin_increment  = w_inc;
    assign o_bin_modulus    = w_mod;

    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> !w_go)
        else $error("word taken with result pending");
    a_fin_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |=> r_ovld)
        else $error("result lost");
    a_go_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> (w_busy || r_ovld))
        else $error("accepted word dropped");

endmodule

// ----- test/baud_checker.sv -----
// Checker for the baud divisor calculator: predicts each result word and compares it.
`timescale 1ns / 1ps
module baud_checker import ubdc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [23:0] i_baud_rate,
    input  logic        i_out_valid,
    input  logic        i_stall_out,
    input  logic        i_settings_valid,
    input  logic [2:0]  i_ref_div_code,
    input  logic [15:0] i_bin_increment,
    input  logic [15:0] i_bin_modulus,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic        ok;
        logic [2:0]  code;
        logic [15:0] incr;
        logic [15:0] modu;
    } t_setting;

    t_setting    expected_settings[$];
    logic [31:0] clock_hz;

    function automatic logic [63:0] gcd64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic t_setting compute_setting(input logic [31:0] clk_hz,
                                                 input logic [23:0] baud);
        t_setting    s;
        logic [63:0] g, num, den, dvd, tnum, tden, ach, diff, m, n, f, lim, b, c;
        lim = 64'(INCREMENT_MAX);
        b   = 64'(baud);
        c   = 64'(clk_hz);
        s   = '0;
        if (baud == 0 || clk_hz == 0) return s;
        g   = gcd64(c, b << 4);
        num = c / g;
        den = (b << 4) / g;
        if (num > lim * 7 || den > lim) begin
            m = (num - 1) / (lim * 7) + 1;
            n = (den - 1) / lim + 1;
            f = (m > n) ? m : n;
            num = num / f;
            den = den / f;
            if (num == 0) num = 1;
            if (den == 0) den = 1;
        end
        dvd = (num - 1) / lim + 1;
        case (dvd)
            1: s.code = 3'd5;
            2: s.code = 3'd4;
            3: s.code = 3'd3;
            4: s.code = 3'd2;
            5: s.code = 3'd1;
            6: s.code = 3'd0;
            7: s.code = 3'd6;
            default: s.code = 3'd5;
        endcase
        g    = gcd64(c, num << 4);
        tnum = c / g;
        tden = (num << 4) / g;
        ach  = (tnum * den) / tden;
        diff = (ach >= b) ? ach - b : b - ach;
        s.ok   = diff < (b / 100) * 3;
        s.incr = 16'(den - 1);
        s.modu = 16'(num / dvd - 1);
        return s;
    endfunction

    assign o_pending = expected_settings.size();

    always @(posedge i_clk) begin
        t_setting e;
        t_setting a;
        if (!i_rst_n) begin
            clock_hz     <= 32'd80000000;
            o_fail_count <= 0;
            expected_settings.delete();
        end else begin
            if (i_cfg_we) clock_hz <= i_cfg_wdata;
            if (i_valid && !i_stall_in)
                expected_settings.push_back(compute_setting(clock_hz, i_baud_rate));
            if (i_out_valid && !i_stall_out) begin
                a = '{i_settings_valid, i_ref_div_code, i_bin_increment, i_bin_modulus};
                if (expected_settings.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10) $display("unexpected word %h", a);
                end else begin
                    e = expected_settings.pop_front();
                    if (e !== a) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display({"mismatch: exp ok=%0d code=%0d inc=%0d mod=%0d,",
                                      " got ok=%0d code=%0d inc=%0d mod=%0d"},
                                     e.ok, e.code, e.incr, e.modu,
                                     a.ok, a.code, a.incr, a.modu);
                    end
                end
            end
        end
    end

endmodule

// ----- test/testbench.sv -----
// Testbench top: stimulus, idling, configuration phases and verdict.
`timescale 1ns / 1ps
module testbench;
    import ubdc_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [31:0] i_cfg_wdata = 0;
    logic        i_valid = 0;
    logic [23:0] i_baud_rate = 0;
    logic        i_stall = 0;
    logic        o_stall, o_valid, o_settings_valid;
    logic [2:0]  o_ref_div_code;
    logic [15:0] o_bin_increment, o_bin_modulus;
    int          fail_count, pending;
    int          quiet_cycles = 0;
    bit          long_hold = 0;   // request a long receiver hold-off
    bit          hold_done = 0;

    localparam int QUIET_LIMIT = 200000;   // cycles with no word accepted or delivered

    always #5 i_clk = ~i_clk;

    uart_baud_divisor_calc dut (.*);

    baud_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .i_stall_in(o_stall), .i_baud_rate(i_baud_rate),
        .i_out_valid(o_valid), .i_stall_out(i_stall),
        .i_settings_valid(o_settings_valid), .i_ref_div_code(o_ref_div_code),
        .i_bin_increment(o_bin_increment), .i_bin_modulus(o_bin_modulus),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: own stall pattern, plus one long hold-off on request.
    always @(posedge i_clk) begin
        int mode;
        if (long_hold && !hold_done) begin
            i_stall <= 1;
            repeat (20000) @(posedge i_clk);
            hold_done <= 1;
            i_stall <= 0;
        end else begin
            mode = $urandom_range(0, 3);
            i_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, 3) == 0);
        end
    end

    // Watchdog: no word accepted or delivered for too long ends the run.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Hand one word to the block and wait until it is taken.
    task automatic send_word(input logic [23:0] baud);
        i_valid     <= 1;
        i_baud_rate <= baud;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic idle_gap();
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
        if (gap > 0) begin
            i_valid     <= 0;
            i_baud_rate <= 24'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Wait for all results, then a latency margin before touching the register.
    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_clock(input logic [31:0] hz);
        i_cfg_we    <= 1;
        i_cfg_wdata <= hz;
        @(posedge i_clk);
        i_cfg_we    <= 0;
    endtask

    // Mostly common baud rates, some fully random.
    function automatic logic [23:0] pick_baud();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 120));
            2: return 24'(32'hFFFFFF - $urandom_range(0, 100));
            default: begin
                case ($urandom_range(0, 7))
                    0: return 24'd9600;
                    1: return 24'd115200;
                    2: return 24'd19200;
                    3: return 24'd921600;
                    4: return 24'd38400;
                    5: return 24'd57600;
                    6: return 24'd4000000;
                    default: return 24'($urandom_range(300, 3000000));
                endcase
            end
        endcase
    endfunction

    logic [31:0] clocks[6];
    logic [23:0] directed[$];

    initial begin
        int burst;
        clocks = '{32'd24000000, 32'd1, 32'hFFFFFFFF, 32'd0, 32'd66000000, 32'd80000000};
        directed = '{24'd0, 24'd1, 24'd99, 24'd100, 24'd9600, 24'd115200, 24'd921600,
                     24'd5000000, 24'hFFFFFF, 24'h555555, 24'hAAAAAA, 24'd300};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed part at the reset clock, then a clock of 1 Hz and a clock of zero.
        foreach (directed[i]) send_word(directed[i]);
        drain();
        write_clock(32'd1);
        send_word(24'd1); send_word(24'd115200);
        drain();
        write_clock(32'd0);
        send_word(24'd9600);
        drain();

        // Random phases over several clock settings.
        foreach (clocks[c]) begin
            write_clock(c == 4 ? $urandom : clocks[c]);
            for (int n = 0; n < 25; ) begin
                burst = $urandom_range(1, 6);
                for (int b = 0; b < burst && n < 25; b++, n++) send_word(pick_baud());
                idle_gap();
                if (c == 2 && n >= 10 && !long_hold) long_hold <= 1;
            end
            drain();   // sender pauses until every result has come
        end

        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule
